/* src/jts_pkg.sv */
// ----------------------------------------------------------------------------
// jts_pkg
// Token codes, scanner modes, error codes and record types shared by the
// JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int LINE_W      = 24;
  localparam int COL_W       = 16;
  localparam int MAX_RESULTS = 3;

  localparam logic [3:0] KIND_VALUE    = 4'd0;
  localparam logic [3:0] KIND_LBRACE   = 4'd1;
  localparam logic [3:0] KIND_RBRACE   = 4'd2;
  localparam logic [3:0] KIND_LBRACKET = 4'd3;
  localparam logic [3:0] KIND_RBRACKET = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_COLON    = 4'd6;
  localparam logic [3:0] KIND_STRING   = 4'd7;
  localparam logic [3:0] KIND_NUMBER   = 4'd8;
  localparam logic [3:0] KIND_TRUE     = 4'd9;
  localparam logic [3:0] KIND_FALSE    = 4'd10;
  localparam logic [3:0] KIND_NULL     = 4'd11;
  localparam logic [3:0] KIND_END      = 4'd12;
  localparam logic [3:0] KIND_ERROR    = 4'd13;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
  localparam logic [2:0] ERR_SHORT_UNI    = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd4;
  localparam logic [2:0] ERR_FRAC_DIGIT   = 3'd5;
  localparam logic [2:0] ERR_EXP_DIGIT    = 3'd6;
  localparam logic [2:0] ERR_BAD_WORD     = 3'd7;

  localparam logic [3:0] MODE_IDLE  = 4'd0;
  localparam logic [3:0] MODE_STR   = 4'd1;
  localparam logic [3:0] MODE_ESC   = 4'd2;
  localparam logic [3:0] MODE_HEX   = 4'd3;
  localparam logic [3:0] MODE_INT   = 4'd4;
  localparam logic [3:0] MODE_DOT   = 4'd5;
  localparam logic [3:0] MODE_FRAC  = 4'd6;
  localparam logic [3:0] MODE_EMARK = 4'd7;
  localparam logic [3:0] MODE_ESIGN = 4'd8;
  localparam logic [3:0] MODE_EXP   = 4'd9;
  localparam logic [3:0] MODE_WORD  = 4'd10;

  localparam logic [1:0] WORD_NONE  = 2'd0;
  localparam logic [1:0] WORD_TRUE  = 2'd1;
  localparam logic [1:0] WORD_FALSE = 2'd2;
  localparam logic [1:0] WORD_NULL  = 2'd3;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] vb;
    logic [2:0] err;
  } tok_t;

  typedef struct packed {
    tok_t              tok;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              last;
  } rec_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [2:0] hex;
    logic [5:0] word;
    logic       consumed;
    logic [1:0] nres;
    tok_t       t0;
    tok_t       t1;
  } scan_t;

  function automatic logic [7:0] word_char(input logic [1:0] id, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (id)
      WORD_TRUE: begin
        case (pos)
          4'd0: ch = "t";
          4'd1: ch = "r";
          4'd2: ch = "u";
          4'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      WORD_FALSE: begin
        case (pos)
          4'd0: ch = "f";
          4'd1: ch = "a";
          4'd2: ch = "l";
          4'd3: ch = "s";
          4'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      WORD_NULL: begin
        case (pos)
          4'd0: ch = "n";
          4'd1: ch = "u";
          4'd2: ch = "l";
          4'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] word_len(input logic [1:0] id);
    logic [3:0] len;
    case (id)
      WORD_TRUE:  len = 4'd4;
      WORD_FALSE: len = 4'd5;
      WORD_NULL:  len = 4'd4;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

/* src/json_token_scanner.sv */
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON lexer: one text byte per request in, tokens and value bytes
// out, each tagged with a saturating line and column.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock while byte_stall is low. Each byte is
// decoded into up to three tokens, which land in a three-entry result buffer
// that drains one token per cycle unless stalled. A byte that yields one
// token or none keeps byte_stall low unless token_stall holds it; a byte
// that yields two or three tokens (a \u escape, a number or word closed by
// the next token, or end of input finishing a pending token) holds byte_stall
// while the buffer drains. String escapes are decoded to one byte, \u is
// passed through raw with the four characters after it, and after a lexical
// error the byte that was not consumed is rescanned from idle in the same
// cycle. An item with end_of_input closes any pending token, emits the end
// token and returns the scanner to its reset state.
module json_token_scanner
  import jts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [7:0]        in_byte,
  input  logic              byte_present,
  input  logic              end_of_input,
  output logic              token_valid,
  input  logic              token_stall,
  output logic [3:0]        kind,
  output logic [7:0]        value_byte,
  output logic [2:0]        error_code,
  output logic [LINE_W-1:0] line_number,
  output logic [COL_W-1:0]  column_number,
  output logic              last_of_run
);

  // scanner state
  logic [3:0]        scan_mode;
  logic [2:0]        hex_left;
  logic [5:0]        word_match;
  logic [LINE_W-1:0] line_count;
  logic [COL_W-1:0]  column_count;

  // result buffer
  rec_t       slot [MAX_RESULTS];
  logic [1:0] count;

  logic accept;
  logic pop;

  // next-state and result assembly
  scan_t             s1, s2;
  logic [3:0]        scan_mode_next;
  logic [2:0]        hex_left_next;
  logic [5:0]        word_match_next;
  logic [LINE_W-1:0] line_count_next;
  logic [COL_W-1:0]  column_count_next;
  logic [LINE_W-1:0] line_a;
  logic [COL_W-1:0]  col_a;
  rec_t              cand [6];
  logic [5:0]        cand_ok;
  rec_t              list4 [4];
  logic [2:0]        n4;
  logic [1:0]        drop_at;
  rec_t              list3 [MAX_RESULTS];
  logic [1:0]        n3;
  tok_t              fin_tok;
  logic              fin_ok;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic tok_t mk_tok(input logic [3:0] k, input logic [7:0] v, input logic [2:0] e);
    tok_t t;
    t.kind = k;
    t.vb   = v;
    t.err  = e;
    return t;
  endfunction

  function automatic tok_t word_tok(input logic [5:0] w);
    tok_t t;
    if ((w[5:4] != WORD_NONE) && (w[3:0] == word_len(w[5:4]))) begin
      case (w[5:4])
        WORD_TRUE:  t = mk_tok(KIND_TRUE, 8'h00, ERR_NONE);
        WORD_FALSE: t = mk_tok(KIND_FALSE, 8'h00, ERR_NONE);
        default:    t = mk_tok(KIND_NULL, 8'h00, ERR_NONE);
      endcase
    end else begin
      t = mk_tok(KIND_ERROR, 8'h00, ERR_BAD_WORD);
    end
    return t;
  endfunction

  // One pass of the byte through the scanner: new mode and up to two tokens.
  function automatic scan_t scan_byte(input logic [3:0] mode, input logic [2:0] hex,
                                      input logic [5:0] word, input logic [7:0] c);
    scan_t      s;
    logic [1:0] id;
    logic [3:0] pos;
    logic [2:0] hex_n;
    logic [7:0] d;
    s          = '0;
    s.mode     = mode;
    s.hex      = hex;
    s.word     = word;
    s.consumed = 1'b1;
    id         = word[5:4];
    pos        = word[3:0];
    hex_n      = (hex != 3'd0) ? hex - 3'd1 : 3'd0;
    d          = c;
    case (mode)
      MODE_IDLE: begin
        if ((c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D))) begin
          s.nres = 2'd0;
        end else if (c == "{") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_LBRACE, 8'h00, ERR_NONE);
        end else if (c == "}") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_RBRACE, 8'h00, ERR_NONE);
        end else if (c == "[") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_LBRACKET, 8'h00, ERR_NONE);
        end else if (c == "]") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_RBRACKET, 8'h00, ERR_NONE);
        end else if (c == ",") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_COMMA, 8'h00, ERR_NONE);
        end else if (c == ":") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_COLON, 8'h00, ERR_NONE);
        end else if (c == "\"") begin
          s.mode = MODE_STR;
        end else if (c == "t") begin
          s.mode = MODE_WORD; s.word = {WORD_TRUE, 4'd1};
        end else if (c == "f") begin
          s.mode = MODE_WORD; s.word = {WORD_FALSE, 4'd1};
        end else if (c == "n") begin
          s.mode = MODE_WORD; s.word = {WORD_NULL, 4'd1};
        end else if (is_digit(c) || (c == "-")) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE); s.mode = MODE_INT;
        end else begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_ERROR, 8'h00, ERR_UNEXPECTED);
        end
      end
      MODE_STR: begin
        if (c == "\"") begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_STRING, 8'h00, ERR_NONE); s.mode = MODE_IDLE;
        end else if (c == "\\") begin
          s.mode = MODE_ESC;
        end else begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE);
        end
      end
      MODE_ESC: begin
        case (c)
          "b":     d = 8'h08;
          "f":     d = 8'h0C;
          "n":     d = 8'h0A;
          "r":     d = 8'h0D;
          "t":     d = 8'h09;
          default: d = c;
        endcase
        if (c == "u") begin
          s.nres = 2'd2;
          s.t0   = mk_tok(KIND_VALUE, "\\", ERR_NONE);
          s.t1   = mk_tok(KIND_VALUE, "u", ERR_NONE);
          s.hex  = 3'd4;
          s.mode = MODE_HEX;
        end else if ((c == "\"") || (c == "\\") || (c == "/") || (c == "b") || (c == "f") ||
                     (c == "n") || (c == "r") || (c == "t")) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, d, ERR_NONE); s.mode = MODE_STR;
        end else begin
          // leave the byte for a rescan from idle
          s.nres = 2'd1; s.t0 = mk_tok(KIND_ERROR, 8'h00, ERR_BAD_ESCAPE);
          s.mode = MODE_IDLE; s.consumed = 1'b0;
        end
      end
      MODE_HEX: begin
        s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE);
        s.hex  = hex_n;
        if (hex_n == 3'd0) s.mode = MODE_STR;
      end
      MODE_INT, MODE_FRAC, MODE_EXP: begin
        if (is_digit(c)) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE);
        end else if ((mode == MODE_INT) && (c == ".")) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE); s.mode = MODE_DOT;
        end else if ((mode != MODE_EXP) && ((c == "e") || (c == "E"))) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE); s.mode = MODE_EMARK;
        end else begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_NUMBER, 8'h00, ERR_NONE);
          s.mode = MODE_IDLE; s.consumed = 1'b0;
        end
      end
      MODE_DOT: begin
        if (is_digit(c)) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE); s.mode = MODE_FRAC;
        end else begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_ERROR, 8'h00, ERR_FRAC_DIGIT);
          s.mode = MODE_IDLE; s.consumed = 1'b0;
        end
      end
      MODE_EMARK, MODE_ESIGN: begin
        if (is_digit(c)) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE); s.mode = MODE_EXP;
        end else if ((mode == MODE_EMARK) && ((c == "+") || (c == "-"))) begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_VALUE, c, ERR_NONE); s.mode = MODE_ESIGN;
        end else begin
          s.nres = 2'd1; s.t0 = mk_tok(KIND_ERROR, 8'h00, ERR_EXP_DIGIT);
          s.mode = MODE_IDLE; s.consumed = 1'b0;
        end
      end
      MODE_WORD: begin
        if (is_alpha(c)) begin
          if ((id != WORD_NONE) && (pos < word_len(id)) && (word_char(id, pos) == c)) begin
            pos = pos + 4'd1;
          end else begin
            id = WORD_NONE;
          end
          s.word = {id, pos};
        end else begin
          s.nres = 2'd1; s.t0 = word_tok(word);
          s.word = 6'd0; s.mode = MODE_IDLE; s.consumed = 1'b0;
        end
      end
      default: begin
        s.mode = MODE_IDLE; s.consumed = 1'b0;
      end
    endcase
    return s;
  endfunction

  assign pop         = token_valid && !token_stall;
  assign byte_stall  = (count > 2'd1) || ((count == 2'd1) && token_stall);
  assign accept      = byte_valid && !byte_stall;

  assign token_valid   = (count != 2'd0);
  assign kind          = slot[0].tok.kind;
  assign value_byte    = slot[0].tok.vb;
  assign error_code    = slot[0].tok.err;
  assign line_number   = slot[0].line;
  assign column_number = slot[0].col;
  assign last_of_run   = slot[0].last;

  always_comb begin
    // first pass, then a rescan from idle when the byte was left over
    s1 = scan_byte(scan_mode, hex_left, word_match, in_byte);
    s2 = scan_byte(s1.mode, s1.hex, s1.word, in_byte);

    line_count_next   = line_count;
    column_count_next = column_count;
    scan_mode_next    = scan_mode;
    hex_left_next     = hex_left;
    word_match_next   = word_match;
    cand_ok           = '0;
    for (int i = 0; i < 6; i++) cand[i] = '0;

    if (byte_present) begin
      if (in_byte == 8'h0A) begin
        if (line_count != {LINE_W{1'b1}}) line_count_next = line_count + LINE_W'(1);
        column_count_next = '0;
      end else if (column_count != {COL_W{1'b1}}) begin
        column_count_next = column_count + COL_W'(1);
      end
      // tokens of the first pass carry the position after its consume
      line_a = s1.consumed ? line_count_next : line_count;
      col_a  = s1.consumed ? column_count_next : column_count;
      cand[0].tok = s1.t0; cand[0].line = line_a; cand[0].col = col_a;
      cand[1].tok = s1.t1; cand[1].line = line_a; cand[1].col = col_a;
      cand_ok[0]  = (s1.nres != 2'd0);
      cand_ok[1]  = (s1.nres == 2'd2);
      cand[2].tok = s2.t0; cand[2].line = line_count_next; cand[2].col = column_count_next;
      cand[3].tok = s2.t1; cand[3].line = line_count_next; cand[3].col = column_count_next;
      cand_ok[2]  = !s1.consumed && (s2.nres != 2'd0);
      cand_ok[3]  = !s1.consumed && (s2.nres == 2'd2);
      scan_mode_next  = s1.consumed ? s1.mode : s2.mode;
      hex_left_next   = s1.consumed ? s1.hex : s2.hex;
      word_match_next = s1.consumed ? s1.word : s2.word;
    end else begin
      line_a = line_count;
      col_a  = column_count;
    end

    // close the pending token at end of input
    fin_ok = 1'b1;
    case (scan_mode_next)
      MODE_STR, MODE_ESC:            fin_tok = mk_tok(KIND_ERROR, 8'h00, ERR_UNTERMINATED);
      MODE_HEX:                      fin_tok = mk_tok(KIND_ERROR, 8'h00, ERR_SHORT_UNI);
      MODE_INT, MODE_FRAC, MODE_EXP: fin_tok = mk_tok(KIND_NUMBER, 8'h00, ERR_NONE);
      MODE_DOT:                      fin_tok = mk_tok(KIND_ERROR, 8'h00, ERR_FRAC_DIGIT);
      MODE_EMARK, MODE_ESIGN:        fin_tok = mk_tok(KIND_ERROR, 8'h00, ERR_EXP_DIGIT);
      MODE_WORD:                     fin_tok = word_tok(word_match_next);
      default: begin
        fin_tok = mk_tok(KIND_VALUE, 8'h00, ERR_NONE);
        fin_ok  = 1'b0;
      end
    endcase
    cand[4].tok = fin_tok;
    cand[4].line = line_count_next; cand[4].col = column_count_next;
    cand[5].tok = mk_tok(KIND_END, 8'h00, ERR_NONE);
    cand[5].line = line_count_next; cand[5].col = column_count_next;
    cand_ok[4] = end_of_input && fin_ok;
    cand_ok[5] = end_of_input;

    if (end_of_input) begin
      scan_mode_next    = MODE_IDLE;
      hex_left_next     = 3'd0;
      word_match_next   = 6'd0;
      line_count_next   = LINE_W'(1);
      column_count_next = '0;
    end

    // pack the candidates, at most four
    n4 = 3'd0;
    for (int i = 0; i < 4; i++) list4[i] = '0;
    for (int i = 0; i < 6; i++) begin
      if (cand_ok[i] && (n4 != 3'd4)) begin
        list4[n4[1:0]] = cand[i];
        n4 = n4 + 3'd1;
      end
    end

    // four results: drop the last value byte among them, else the last result
    drop_at = 2'd3;
    for (int k = 0; k < 4; k++) begin
      if (list4[k].tok.kind == KIND_VALUE) drop_at = 2'(k);
    end
    for (int j = 0; j < MAX_RESULTS; j++) begin
      if ((n4 == 3'd4) && (2'(j) >= drop_at)) list3[j] = list4[j + 1];
      else list3[j] = list4[j];
    end
    n3 = (n4 == 3'd4) ? 2'd3 : n4[1:0];
    for (int j = 0; j < MAX_RESULTS; j++) begin
      list3[j].last = (2'(j + 1) == n3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= MODE_IDLE;
      hex_left     <= 3'd0;
      word_match   <= 6'd0;
      line_count   <= LINE_W'(1);
      column_count <= '0;
      count        <= 2'd0;
    end else begin
      if (accept) begin
        scan_mode    <= scan_mode_next;
        hex_left     <= hex_left_next;
        word_match   <= word_match_next;
        line_count   <= line_count_next;
        column_count <= column_count_next;
        count        <= n3;
      end else if (pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // result slots: load on a new request, else advance as tokens leave
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < MAX_RESULTS; j++) slot[j] <= list3[j];
    end else if (pop) begin
      for (int j = 0; j < MAX_RESULTS - 1; j++) slot[j] <= slot[j + 1];
    end
  end

  a_last_marks_tail: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (last_of_run == (count == 2'd1)))
    else $error("last_of_run does not match the buffered token count");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_input) |=>
      ((scan_mode == MODE_IDLE) && (line_count == LINE_W'(1)) && (column_count == '0)))
    else $error("scanner state not cleared after end of input");

  a_hex_only_in_hex: assert property (@(posedge clk) disable iff (rst)
    (scan_mode != MODE_HEX) |-> (hex_left == 3'd0))
    else $error("hex counter live outside a unicode escape");

  a_word_only_in_word: assert property (@(posedge clk) disable iff (rst)
    (scan_mode != MODE_WORD) |-> (word_match == 6'd0))
    else $error("word match live outside a word");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> ((count == 2'd0) || ((count == 2'd1) && pop)))
    else $error("new request taken while buffered tokens remain");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_token_scanner. A directed table of requests
// covers the corner cases of the lexer. Random JSON fragments follow: strings
// with escapes, numbers, words, punctuation, noise and truncated documents.
// Every token is checked against a cycle-free scanner model kept in the bench,
// and both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import jts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] b;
    logic       present;
    logic       eoi;
    logic       chk;
    logic [3:0] kind;
    logic [2:0] err;
  } step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  logic [7:0]        in_byte = 8'h00;
  logic              byte_present = 1'b0;
  logic              end_of_input = 1'b0;
  logic              token_valid;
  logic              token_stall = 1'b0;
  logic [3:0]        kind;
  logic [7:0]        value_byte;
  logic [2:0]        error_code;
  logic [LINE_W-1:0] line_number;
  logic [COL_W-1:0]  column_number;
  logic              last_of_run;

  // Typed-in first token of a directed request, when chk is set.
  logic              row_chk = 1'b0;
  logic [3:0]        row_kind = KIND_VALUE;
  logic [2:0]        row_err = ERR_NONE;

  logic              calm = 1'b0;
  int                hold_left = 0;
  int                miss_count = 0;

  // Scanner model state
  logic [3:0]        mode_q;
  logic [2:0]        hex_q;
  logic [1:0]        word_id_q;
  logic [3:0]        word_pos_q;
  logic [LINE_W-1:0] line_q;
  logic [COL_W-1:0]  col_q;
  string             spelling [4] = '{"", "true", "false", "null"};

  rec_t              item_toks[$];
  rec_t              tokens_due[$];
  step_t             doc[$];

  step_t plan [33] = '{
    '{"{",   1'b1, 1'b0, 1'b1, KIND_LBRACE, ERR_NONE},
    '{"\"",  1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{8'h01, 1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"\\",  1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"u",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{8'hFF, 1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{8'h00, 1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"\"",  1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"z",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"\\",  1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"x",   1'b1, 1'b0, 1'b1, KIND_ERROR,  ERR_BAD_ESCAPE},
    '{"-",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{".",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"}",   1'b1, 1'b0, 1'b1, KIND_ERROR,  ERR_FRAC_DIGIT},
    '{"9",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"E",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"-",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{",",   1'b1, 1'b0, 1'b1, KIND_ERROR,  ERR_EXP_DIGIT},
    '{"n",   1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"u",   1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"l",   1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"l",   1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    // word closed by a digit at end of input: the digit's value byte is dropped
    '{"5",   1'b1, 1'b1, 1'b1, KIND_NULL,   ERR_NONE},
    '{8'h00, 1'b0, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_END,    ERR_NONE},
    '{"\"",  1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"\\",  1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"u",   1'b1, 1'b1, 1'b1, KIND_VALUE,  ERR_NONE},
    '{"\"",  1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"a",   1'b1, 1'b0, 1'b1, KIND_VALUE,  ERR_NONE},
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_ERROR,  ERR_UNTERMINATED},
    '{"t",   1'b1, 1'b0, 1'b0, KIND_VALUE,  ERR_NONE},
    '{"r",   1'b1, 1'b1, 1'b1, KIND_ERROR,  ERR_BAD_WORD}
  };

  json_token_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .in_byte       (in_byte),
    .byte_present  (byte_present),
    .end_of_input  (end_of_input),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .kind          (kind),
    .value_byte    (value_byte),
    .error_code    (error_code),
    .line_number   (line_number),
    .column_number (column_number),
    .last_of_run   (last_of_run)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic void clear_scanner();
    mode_q = MODE_IDLE;
    hex_q = '0;
    word_id_q = WORD_NONE;
    word_pos_q = '0;
    line_q = LINE_W'(1);
    col_q = '0;
  endfunction

  function automatic void emit(input logic [3:0] k, input logic [7:0] v, input logic [2:0] e);
    rec_t r;
    r.tok.kind = k;
    r.tok.vb = v;
    r.tok.err = e;
    r.line = line_q;
    r.col = col_q;
    r.last = 1'b0;
    if (item_toks.size() < 4) item_toks.push_back(r);
  endfunction

  function automatic void advance_position(input logic [7:0] c);
    if (c == 8'h0A) begin
      if (line_q != '1) line_q = line_q + 1'b1;
      col_q = '0;
    end else if (col_q != '1) begin
      col_q = col_q + 1'b1;
    end
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void close_word();
    if (word_id_q != WORD_NONE && word_pos_q == spelling[word_id_q].len()) begin
      case (word_id_q)
        WORD_TRUE:  emit(KIND_TRUE, 8'h00, ERR_NONE);
        WORD_FALSE: emit(KIND_FALSE, 8'h00, ERR_NONE);
        default:    emit(KIND_NULL, 8'h00, ERR_NONE);
      endcase
    end else begin
      emit(KIND_ERROR, 8'h00, ERR_BAD_WORD);
    end
    word_id_q = WORD_NONE;
    word_pos_q = '0;
  endfunction

  // Returns 0 when the byte is left for a second scan from idle.
  function automatic bit scan_byte(input logic [7:0] c);
    logic [3:0] punct;
    logic [7:0] plain;
    bit         blank;
    bit         took;
    took = 1'b1;
    case (mode_q)
      MODE_IDLE: begin
        advance_position(c);
        blank = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
        case (c)
          "{":     punct = KIND_LBRACE;
          "}":     punct = KIND_RBRACE;
          "[":     punct = KIND_LBRACKET;
          "]":     punct = KIND_RBRACKET;
          ",":     punct = KIND_COMMA;
          ":":     punct = KIND_COLON;
          default: punct = KIND_VALUE;  // not punctuation
        endcase
        if (!blank) begin
          if (punct != KIND_VALUE) begin
            emit(punct, 8'h00, ERR_NONE);
          end else if (c == "\"") begin
            mode_q = MODE_STR;
          end else if (c == "t" || c == "f" || c == "n") begin
            word_id_q = (c == "t") ? WORD_TRUE : (c == "f") ? WORD_FALSE : WORD_NULL;
            word_pos_q = 4'd1;
            mode_q = MODE_WORD;
          end else if (is_digit(c) || c == "-") begin
            emit(KIND_VALUE, c, ERR_NONE);
            mode_q = MODE_INT;
          end else begin
            emit(KIND_ERROR, 8'h00, ERR_UNEXPECTED);
          end
        end
      end
      MODE_STR: begin
        advance_position(c);
        if (c == "\"") begin
          emit(KIND_STRING, 8'h00, ERR_NONE);
          mode_q = MODE_IDLE;
        end else if (c == "\\") begin
          mode_q = MODE_ESC;
        end else begin
          emit(KIND_VALUE, c, ERR_NONE);
        end
      end
      MODE_ESC: begin
        case (c)
          "\"", "\\", "/": plain = c;
          "b":     plain = 8'h08;
          "f":     plain = 8'h0C;
          "n":     plain = 8'h0A;
          "r":     plain = 8'h0D;
          "t":     plain = 8'h09;
          default: plain = 8'h00;
        endcase
        if (c == "u") begin
          // pass the escape through raw
          advance_position(c);
          emit(KIND_VALUE, "\\", ERR_NONE);
          emit(KIND_VALUE, "u", ERR_NONE);
          hex_q = 3'd4;
          mode_q = MODE_HEX;
        end else if (plain != 8'h00) begin
          advance_position(c);
          emit(KIND_VALUE, plain, ERR_NONE);
          mode_q = MODE_STR;
        end else begin
          emit(KIND_ERROR, 8'h00, ERR_BAD_ESCAPE);
          mode_q = MODE_IDLE;
          took = 1'b0;
        end
      end
      MODE_HEX: begin
        advance_position(c);
        emit(KIND_VALUE, c, ERR_NONE);
        if (hex_q != 3'd0) hex_q = hex_q - 1'b1;
        if (hex_q == 3'd0) mode_q = MODE_STR;
      end
      MODE_INT, MODE_FRAC, MODE_EXP: begin
        if (is_digit(c)) begin
          advance_position(c);
          emit(KIND_VALUE, c, ERR_NONE);
        end else if (mode_q == MODE_INT && c == ".") begin
          advance_position(c);
          emit(KIND_VALUE, c, ERR_NONE);
          mode_q = MODE_DOT;
        end else if (mode_q != MODE_EXP && (c == "e" || c == "E")) begin
          advance_position(c);
          emit(KIND_VALUE, c, ERR_NONE);
          mode_q = MODE_EMARK;
        end else begin
          emit(KIND_NUMBER, 8'h00, ERR_NONE);
          mode_q = MODE_IDLE;
          took = 1'b0;
        end
      end
      MODE_DOT: begin
        if (is_digit(c)) begin
          advance_position(c);
          emit(KIND_VALUE, c, ERR_NONE);
          mode_q = MODE_FRAC;
        end else begin
          emit(KIND_ERROR, 8'h00, ERR_FRAC_DIGIT);
          mode_q = MODE_IDLE;
          took = 1'b0;
        end
      end
      MODE_EMARK, MODE_ESIGN: begin
        if (is_digit(c)) begin
          advance_position(c);
          emit(KIND_VALUE, c, ERR_NONE);
          mode_q = MODE_EXP;
        end else if (mode_q == MODE_EMARK && (c == "+" || c == "-")) begin
          advance_position(c);
          emit(KIND_VALUE, c, ERR_NONE);
          mode_q = MODE_ESIGN;
        end else begin
          emit(KIND_ERROR, 8'h00, ERR_EXP_DIGIT);
          mode_q = MODE_IDLE;
          took = 1'b0;
        end
      end
      MODE_WORD: begin
        if (is_letter(c)) begin
          advance_position(c);
          if (word_id_q != WORD_NONE && word_pos_q < spelling[word_id_q].len() &&
              spelling[word_id_q][word_pos_q] == c)
            word_pos_q = word_pos_q + 1'b1;
          else
            word_id_q = WORD_NONE;
        end else begin
          close_word();
          mode_q = MODE_IDLE;
          took = 1'b0;
        end
      end
      default: begin
        mode_q = MODE_IDLE;
        took = 1'b0;
      end
    endcase
    return took;
  endfunction

  // Work out the tokens of one request and queue them as expected.
  function automatic void scan_request(input logic [7:0] c, input logic present,
                                       input logic eoi);
    item_toks.delete();
    if (present) begin
      if (!scan_byte(c)) void'(scan_byte(c));
    end
    if (eoi) begin
      case (mode_q)
        MODE_STR, MODE_ESC:            emit(KIND_ERROR, 8'h00, ERR_UNTERMINATED);
        MODE_HEX:                      emit(KIND_ERROR, 8'h00, ERR_SHORT_UNI);
        MODE_INT, MODE_FRAC, MODE_EXP: emit(KIND_NUMBER, 8'h00, ERR_NONE);
        MODE_DOT:                      emit(KIND_ERROR, 8'h00, ERR_FRAC_DIGIT);
        MODE_EMARK, MODE_ESIGN:        emit(KIND_ERROR, 8'h00, ERR_EXP_DIGIT);
        MODE_WORD:                     close_word();
        default: ;
      endcase
      emit(KIND_END, 8'h00, ERR_NONE);
      clear_scanner();
    end
    // only three tokens fit: drop the last value byte, else the last token
    if (item_toks.size() > MAX_RESULTS) begin
      for (int k = MAX_RESULTS; k >= 0; k--) begin
        if (item_toks[k].tok.kind == KIND_VALUE) begin
          item_toks.delete(k);
          break;
        end
      end
      while (item_toks.size() > MAX_RESULTS) void'(item_toks.pop_back());
    end
    if (item_toks.size() != 0) item_toks[item_toks.size() - 1].last = 1'b1;
    foreach (item_toks[k]) tokens_due.push_back(item_toks[k]);
  endfunction

  function automatic void flag_miss(input string msg);
    miss_count++;
    if (miss_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    rec_t want;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        scan_request(in_byte, byte_present, end_of_input);
        if (row_chk && (item_toks.size() == 0 || item_toks[0].tok.kind != row_kind ||
                        item_toks[0].tok.err != row_err))
          flag_miss($sformatf("directed byte %h: table kind %0d err %0d, model gave %0d tokens",
                              in_byte, row_kind, row_err, item_toks.size()));
      end
      if (token_valid && !token_stall) begin
        if (tokens_due.size() == 0) begin
          flag_miss($sformatf("token kind %0d with nothing expected", kind));
        end else begin
          want = tokens_due.pop_front();
          if (kind !== want.tok.kind || value_byte !== want.tok.vb ||
              error_code !== want.tok.err || line_number !== want.line ||
              column_number !== want.col || last_of_run !== want.last)
            flag_miss($sformatf({"exp kind %0d byte %h err %0d line %0d col %0d last %b, ",
                                 "got kind %0d byte %h err %0d line %0d col %0d last %b"},
                                want.tok.kind, want.tok.vb, want.tok.err, want.line,
                                want.col, want.last, kind, value_byte, error_code,
                                line_number, column_number, last_of_run));
        end
      end
    end
  end

  // Stall the token side in random bursts.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      token_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 6);
      token_stall <= 1'b1;
    end else begin
      token_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic offer(input step_t s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    in_byte <= s.b;
    byte_present <= s.present;
    end_of_input <= s.eoi;
    row_chk <= s.chk;
    row_kind <= s.kind;
    row_err <= s.err;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  function automatic void add_text_byte(input logic [7:0] b);
    step_t s;
    s = '0;
    s.b = b;
    s.present = 1'b1;
    doc.push_back(s);
  endfunction

  function automatic void add_fragment();
    string      punct_set;
    string      esc_set;
    string      w;
    logic [7:0] b;
    step_t      s;
    int         start;
    punct_set = "{}[],:";
    esc_set = "\"\\/bfnrt";
    case ($urandom_range(0, 11))
      0, 1: begin
        add_text_byte(punct_set[$urandom_range(0, 5)]);
        if ($urandom_range(0, 1)) add_text_byte(" ");
      end
      2, 3: begin
        start = doc.size();
        add_text_byte("\"");
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0: begin
              add_text_byte("\\");
              add_text_byte(esc_set[$urandom_range(0, 7)]);
            end
            1: begin
              add_text_byte("\\");
              add_text_byte("u");
              repeat (4) add_text_byte(8'($urandom_range(0, 255)));
            end
            2: begin
              b = 8'($urandom_range(0, 255));
              if (b == "\"" || b == "\\") b = "q";
              add_text_byte(b);
            end
            default: begin
              b = 8'($urandom_range(32, 126));
              if (b == "\"" || b == "\\") b = "k";
              add_text_byte(b);
            end
          endcase
        end
        if ($urandom_range(0, 7) == 0) begin
          // cut the document off inside the string
          repeat ($urandom_range(0, 3)) if (doc.size() > start + 1) void'(doc.pop_back());
          doc[doc.size() - 1].eoi = 1'b1;
        end else begin
          add_text_byte("\"");
        end
      end
      4, 5: begin
        b = 8'($urandom_range(0, 1));
        if (b[0]) add_text_byte("-");
        repeat (b[0] ? $urandom_range(0, 3) : $urandom_range(1, 3))
          add_text_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          add_text_byte(".");
          repeat ($urandom_range(1, 2)) add_text_byte(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0) begin
          add_text_byte($urandom_range(0, 1) ? "e" : "E");
          if ($urandom_range(0, 1)) add_text_byte($urandom_range(0, 1) ? "+" : "-");
          repeat ($urandom_range(1, 2)) add_text_byte(8'("0" + $urandom_range(0, 9)));
        end
      end
      6: begin
        case ($urandom_range(0, 3))
          0: w = "true";
          1: w = "false";
          2: w = "null";
          default: begin
            w = "tfn";
            start = $urandom_range(0, 2);
            w = w.substr(start, start);
          end
        endcase
        for (int j = 0; j < w.len(); j++) add_text_byte(w[j]);
        if (w.len() == 1) begin
          repeat ($urandom_range(0, 4)) begin
            b = 8'("a" + $urandom_range(0, 25));
            if ($urandom_range(0, 3) == 0) b = b & 8'hDF;
            add_text_byte(b);
          end
        end
      end
      7: begin
        b = ($urandom_range(0, 2) == 0) ? " " : 8'($urandom_range(9, 13));
        add_text_byte(b);
      end
      8: begin
        // number left waiting for a digit
        add_text_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          add_text_byte(".");
        end else begin
          add_text_byte("e");
          if ($urandom_range(0, 1)) add_text_byte("+");
        end
      end
      9: begin
        add_text_byte("\"");
        add_text_byte("\\");
        add_text_byte(8'($urandom_range(0, 255)));
      end
      10: add_text_byte(8'($urandom_range(0, 255)));
      default: begin
        s = '0;
        case ($urandom_range(0, 2))
          0: begin
            s.eoi = 1'b1;
            doc.push_back(s);
          end
          1: doc.push_back(s);
          default: begin
            if (doc.size() != 0) doc[doc.size() - 1].eoi = 1'b1;
          end
        endcase
      end
    endcase
  endfunction

  initial begin
    clear_scanner();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) offer(plan[k]);

    while (doc.size() < 237) add_fragment();
    foreach (doc[k]) begin
      if (k >= doc.size() - 50)
        calm <= 1'b1;
      else if (k % 40 == 0)
        calm <= ($urandom_range(0, 3) == 0);
      offer(doc[k]);
    end
    byte_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (miss_count == 0 && tokens_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
